/* hdl/cap_pkg.sv */
package cap_pkg;

    localparam int IN_W       = 16;
    localparam int XY_W       = 19;     // input plus CORDIC gain plus sign margin
    localparam int PHASE_W    = 20;     // Q3.17 radians
    localparam int ITERATIONS = 16;
    localparam int ITERS_PER_STAGE = 4;
    localparam int NUM_STAGES = (ITERATIONS + ITERS_PER_STAGE - 1) / ITERS_PER_STAGE;
    localparam int DELAY      = 8;
    localparam int SHIFT_W    = 4;

    localparam logic signed [PHASE_W-1:0] HALF_PI_Q17 = 20'sd205887;

    // atan(2^-i) * 2^17, rounded
    localparam logic signed [PHASE_W-1:0] ATAN_Q17 [16] = '{
        20'sd102944, 20'sd60771, 20'sd32110, 20'sd16299,
        20'sd8181,   20'sd4095,  20'sd2048,  20'sd1024,
        20'sd512,    20'sd256,   20'sd128,   20'sd64,
        20'sd32,     20'sd16,    20'sd8,     20'sd4
    };

    typedef struct packed {
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic signed [PHASE_W-1:0] z;
    } cap_vec_t;

endpackage

/* hdl/cap_rot.sv */
module cap_rot
    import cap_pkg::*;
(
    input  logic [SHIFT_W-1:0]        shift,
    input  logic signed [PHASE_W-1:0] atan_val,
    input  cap_vec_t                  din,
    output cap_vec_t                  dout
);

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    assign xs = din.x >>> shift;
    assign ys = din.y >>> shift;

    always_comb
    begin
        if (!din.y[XY_W-1])
        begin
            dout.x = din.x + ys;
            dout.y = din.y - xs;
            dout.z = din.z + atan_val;
        end
        else
        begin
            dout.x = din.x - ys;
            dout.y = din.y + xs;
            dout.z = din.z - atan_val;
        end
    end

endmodule

/* hdl/cordic_atan2_phase.sv */
// channel | signals                              | width
// --------+--------------------------------------+--------------------------
// in      | in_valid, in_stall, sample_real/imag | 16 + 16, signed
// out     | out_valid, out_stall, phase          | 20, signed Q3.17 radians
//
// One request per cycle sustained while the output is not stalled.
// Accepted requests pass one pre-rotation stage, four CORDIC stages of
// four micro-rotations each, and the output stage with the 8-deep delay line.
// Each phase comes from the request 8 requests earlier; zero after reset.
// A stalled output freezes the whole pipeline and raises in_stall.
module cordic_atan2_phase
    import cap_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [IN_W-1:0]    sample_real,
    input  logic signed [IN_W-1:0]    sample_imag,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [PHASE_W-1:0] phase
);

    logic                      adv;
    logic [NUM_STAGES:0]       valid_reg;
    cap_vec_t                  vec_reg [NUM_STAGES+1];
    cap_vec_t                  pre_next;
    logic signed [XY_W-1:0]    x_in;
    logic signed [XY_W-1:0]    y_in;
    logic signed [PHASE_W-1:0] dly_reg [DELAY];
    logic                      out_valid_reg;
    logic signed [PHASE_W-1:0] phase_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    assign x_in = {{(XY_W-IN_W){sample_real[IN_W-1]}}, sample_real};
    assign y_in = {{(XY_W-IN_W){sample_imag[IN_W-1]}}, sample_imag};

    // left half plane: turn by +-pi/2 into the right half plane
    always_comb
    begin
        if (!x_in[XY_W-1])
        begin
            pre_next.x = x_in;
            pre_next.y = y_in;
            pre_next.z = '0;
        end
        else if (!y_in[XY_W-1])
        begin
            pre_next.x = y_in;
            pre_next.y = -x_in;
            pre_next.z = HALF_PI_Q17;
        end
        else
        begin
            pre_next.x = -y_in;
            pre_next.y = x_in;
            pre_next.z = -HALF_PI_Q17;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg[0] <= pre_next;
        end
    end

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        cap_vec_t chain [ITERS_PER_STAGE+1];

        assign chain[0] = vec_reg[s];

        for (genvar k = 0; k < ITERS_PER_STAGE; k++)
        begin : g_iter
            if (s * ITERS_PER_STAGE + k < ITERATIONS)
            begin : g_rot
                cap_rot u_rot (
                    .shift    (SHIFT_W'(s * ITERS_PER_STAGE + k)),
                    .atan_val (ATAN_Q17[s * ITERS_PER_STAGE + k]),
                    .din      (chain[k]),
                    .dout     (chain[k+1])
                );
            end
            else
            begin : g_pass
                assign chain[k+1] = chain[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                vec_reg[s+1] <= chain[ITERS_PER_STAGE];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < DELAY; k++)
            begin
                dly_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[NUM_STAGES-1:0], in_valid};
            out_valid_reg <= valid_reg[NUM_STAGES];
            if (valid_reg[NUM_STAGES])
            begin
                for (int k = DELAY - 1; k > 0; k--)
                begin
                    dly_reg[k] <= dly_reg[k-1];
                end
                dly_reg[0] <= vec_reg[NUM_STAGES].z;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && valid_reg[NUM_STAGES])
        begin
            phase_reg <= dly_reg[DELAY-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign phase     = phase_reg;

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input accepted while output is stalled");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted request not captured in first stage");

    a_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && valid_reg[NUM_STAGES]) |=> out_valid)
        else $error("finished request did not reach output register");

endmodule
